### design/rlee_pkg.sv
// ----------------------------------------------------------------------------
// rlee_pkg
// shared codes, job descriptor and constant tables of the rgb led effect engine
// ----------------------------------------------------------------------------
package rlee_pkg;

    localparam int LED_COUNT = 6;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [2:0] ACT_TICK   = 3'd0;
    localparam logic [2:0] ACT_COLOR  = 3'd1;
    localparam logic [2:0] ACT_METEOR = 3'd2;
    localparam logic [2:0] ACT_BREATH = 3'd3;
    localparam logic [2:0] ACT_CLEAR  = 3'd4;

    localparam logic [2:0] LED_NONE = 3'd7;

    localparam logic [1:0] MODE_CLEAR  = 2'd0;
    localparam logic [1:0] MODE_COLOR  = 2'd1;
    localparam logic [1:0] MODE_METEOR = 2'd2;
    localparam logic [1:0] MODE_BREATH = 2'd3;

    localparam logic [1:0] OP_WRITE_SHOW = 2'd0;
    localparam logic [1:0] OP_WRITE_BUF  = 2'd1;
    localparam logic [1:0] OP_LATCH      = 2'd2;
    localparam logic [1:0] OP_CLEAR_ALL  = 2'd3;

    localparam logic [1:0] JOB_WRITE  = 2'd0;
    localparam logic [1:0] JOB_METEOR = 2'd1;
    localparam logic [1:0] JOB_BREATH = 2'd2;

    localparam logic [1:0] SPEED_MAX = 2'd2;

    localparam logic [7:0] STEP_FALL_FLAG = 8'h80;
    localparam logic [7:0] STEP_FALL_END  = 8'h81;
    localparam logic [7:0] STEP_RISE_BASE = 8'h01;

    localparam int RECIP_SHIFT = 16;
    localparam int PROD_W      = 15;
    localparam int RECIP_W     = 12;
    localparam int QUOT_W      = PROD_W + RECIP_W - RECIP_SHIFT;

    typedef struct packed {
        logic [1:0] kind;
        logic       clear_first;
        logic [2:0] led;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [1:0] spd;
        logic [6:0] stp;
    } job_t;

    function automatic logic [7:0] meteor_period(input logic [1:0] s);
        logic [7:0] p;
        unique case (s)
            2'd0:    p = 8'd200;
            2'd1:    p = 8'd140;
            default: p = 8'd80;
        endcase
        return p;
    endfunction

    function automatic logic [6:0] breath_period(input logic [1:0] s);
        logic [6:0] p;
        unique case (s)
            2'd0:    p = 7'd50;
            2'd1:    p = 7'd35;
            default: p = 7'd25;
        endcase
        return p;
    endfunction

    // floor(2^RECIP_SHIFT / period)
    function automatic logic [RECIP_W-1:0] breath_recip(input logic [1:0] s);
        logic [RECIP_W-1:0] m;
        unique case (s)
            2'd0:    m = RECIP_W'((1 << RECIP_SHIFT) / 50);
            2'd1:    m = RECIP_W'((1 << RECIP_SHIFT) / 35);
            default: m = RECIP_W'((1 << RECIP_SHIFT) / 25);
        endcase
        return m;
    endfunction

    // 0 stays 0 (all leds), ids above LED_COUNT have LED_COUNT subtracted once
    function automatic logic [2:0] map_led(input logic [3:0] id);
        logic [3:0] v;
        if (id == 4'd0) begin
            v = 4'd0;
        end else if (id > 4'(LED_COUNT)) begin
            v = id - 4'(LED_COUNT);
        end else begin
            v = id;
        end
        return v[2:0];
    endfunction

endpackage

### design/rlee_front.sv
// ----------------------------------------------------------------------------
// rlee_front
// accepts requests, keeps the effect state and time, and issues jobs
// ----------------------------------------------------------------------------
module rlee_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [31:0]       s_tdata,  // led_index, speed, red, green, blue, clear_others
    input  logic [2:0]        s_tuser,  // action
    input  logic              q_full,
    output logic              q_push,
    output rlee_pkg::job_t    q_job
);
    import rlee_pkg::*;

    logic [1:0]  mode_reg, mode_next;
    logic [1:0]  speed_reg, speed_next;
    logic [7:0]  red_reg, red_next;
    logic [7:0]  green_reg, green_next;
    logic [7:0]  blue_reg, blue_next;
    logic [2:0]  pos_reg, pos_next;
    logic [7:0]  step_reg, step_next;
    logic [31:0] now_reg, now_next;
    logic [31:0] dl_reg, dl_next;

    logic        accept;
    logic [2:0]  in_led;
    logic [1:0]  in_spd;
    logic [7:0]  in_red, in_green, in_blue;
    logic        in_clr;
    logic        eval_en, clr_first, fire;
    logic [31:0] now_e, dl_e;
    logic [7:0]  step_inc;
    logic [6:0]  per;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    assign in_led   = s_tdata[2:0];
    assign in_spd   = (s_tdata[4:3] > SPEED_MAX) ? SPEED_MAX : s_tdata[4:3];
    assign in_red   = s_tdata[12:5];
    assign in_green = s_tdata[20:13];
    assign in_blue  = s_tdata[28:21];
    assign in_clr   = s_tdata[29];

    always_comb begin
        mode_next  = mode_reg;
        speed_next = speed_reg;
        red_next   = red_reg;
        green_next = green_reg;
        blue_next  = blue_reg;
        pos_next   = pos_reg;
        step_next  = step_reg;
        now_next   = now_reg;
        dl_e       = dl_reg;
        now_e      = now_reg;
        eval_en    = 1'b0;
        clr_first  = 1'b0;
        fire       = 1'b0;
        q_push     = 1'b0;
        q_job      = '0;
        if (accept) begin
            unique case (s_tuser)
                ACT_TICK: begin
                    now_next = now_reg + 32'd1;
                    now_e    = now_next;
                    eval_en  = 1'b1;
                end
                ACT_COLOR: begin
                    if (in_led != LED_NONE) begin
                        mode_next         = MODE_COLOR;
                        q_push            = 1'b1;
                        q_job.kind        = JOB_WRITE;
                        q_job.clear_first = in_clr;
                        q_job.led         = in_led;
                        q_job.red         = in_red;
                        q_job.green       = in_green;
                        q_job.blue        = in_blue;
                    end
                end
                ACT_METEOR: begin
                    eval_en = 1'b1;
                    if (mode_reg != MODE_METEOR || speed_reg != in_spd ||
                        red_reg != in_red || green_reg != in_green ||
                        blue_reg != in_blue) begin
                        mode_next  = MODE_METEOR;
                        speed_next = in_spd;
                        red_next   = in_red;
                        green_next = in_green;
                        blue_next  = in_blue;
                        pos_next   = 3'd0;
                        dl_e       = now_reg;
                        clr_first  = 1'b1;
                    end
                end
                ACT_BREATH: begin
                    if (in_led != LED_NONE) begin
                        eval_en = 1'b1;
                        if (mode_reg != MODE_BREATH || pos_reg != in_led ||
                            speed_reg != in_spd || red_reg != in_red ||
                            green_reg != in_green || blue_reg != in_blue) begin
                            mode_next  = MODE_BREATH;
                            speed_next = in_spd;
                            red_next   = in_red;
                            green_next = in_green;
                            blue_next  = in_blue;
                            pos_next   = in_led;
                            step_next  = 8'd0;
                            dl_e       = now_reg;
                            clr_first  = 1'b1;
                        end
                    end
                end
                ACT_CLEAR: begin
                    if (in_led != LED_NONE) begin
                        mode_next  = MODE_CLEAR;
                        q_push     = 1'b1;
                        q_job.kind = JOB_WRITE;
                        q_job.led  = in_led;
                    end
                end
                default: ;
            endcase
        end

        dl_next  = dl_e;
        per      = breath_period(speed_next);
        step_inc = step_next + 8'd1;
        if (eval_en && now_e >= dl_e) begin
            if (mode_next == MODE_METEOR) begin
                fire              = 1'b1;
                q_job.kind        = JOB_METEOR;
                q_job.led         = pos_next;
                dl_next           = dl_e + 32'(meteor_period(speed_next));
                pos_next          = (pos_next >= 3'(LED_COUNT)) ? 3'd1 : pos_next + 3'd1;
            end else if (mode_next == MODE_BREATH) begin
                fire              = 1'b1;
                q_job.kind        = JOB_BREATH;
                q_job.led         = pos_next;
                q_job.stp         = step_next[6:0];
                dl_next           = now_e + 32'(per);
                if (step_next[7]) begin
                    step_next = (step_next - 8'd1 == STEP_FALL_END) ?
                                STEP_RISE_BASE : step_next - 8'd1;
                end else begin
                    step_next = (step_inc == {1'b0, per}) ?
                                (STEP_FALL_FLAG | {1'b0, per}) : step_inc;
                end
            end
        end
        if (eval_en && (fire || clr_first)) begin
            q_push            = 1'b1;
            q_job.clear_first = clr_first;
            q_job.red         = red_next;
            q_job.green       = green_next;
            q_job.blue        = blue_next;
            q_job.spd         = speed_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_CLEAR;
            speed_reg <= 2'd0;
            red_reg   <= 8'd0;
            green_reg <= 8'd0;
            blue_reg  <= 8'd0;
            pos_reg   <= 3'd0;
            step_reg  <= 8'd0;
            now_reg   <= 32'd0;
            dl_reg    <= 32'd0;
        end else begin
            mode_reg  <= mode_next;
            speed_reg <= speed_next;
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
            pos_reg   <= pos_next;
            step_reg  <= step_next;
            now_reg   <= now_next;
            dl_reg    <= dl_next;
        end
    end

endmodule

### design/rlee_queue.sv
// ----------------------------------------------------------------------------
// rlee_queue
// short job queue between the front and the back
// ----------------------------------------------------------------------------
module rlee_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  rlee_pkg::job_t    push_job,
    output logic              full,
    input  logic              pop,
    output rlee_pkg::job_t    pop_job,
    output logic              empty
);
    import rlee_pkg::*;

    job_t              slot_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_reg;
    logic [QPTR_W-1:0] rd_reg;
    logic [QCNT_W-1:0] cnt_reg;

    assign full    = (cnt_reg == QCNT_W'(QDEPTH));
    assign empty   = (cnt_reg == '0);
    assign pop_job = slot_reg[rd_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) begin
                wr_reg <= wr_reg + QPTR_W'(1);
            end
            if (pop) begin
                rd_reg <= rd_reg + QPTR_W'(1);
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + QCNT_W'(1);
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - QCNT_W'(1);
            end
        end
    end

endmodule

### design/rlee_back.sv
// ----------------------------------------------------------------------------
// rlee_back
// expands jobs into led writes in an output register, one a cycle unless stalled
// ----------------------------------------------------------------------------
module rlee_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_empty,
    input  rlee_pkg::job_t    q_job,
    output logic              q_pop,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [31:0]       m_tdata,  // led_select, out_red, out_green, out_blue
    output logic [1:0]        m_tuser,  // op
    output logic              m_tlast
);
    import rlee_pkg::*;

    job_t              job_reg;
    logic              busy_reg;
    logic [2:0]        step_reg;
    logic [1:0]        bwait_reg;
    logic              out_valid_reg;
    logic [1:0]        op_reg;
    logic [2:0]        led_reg;
    logic [7:0]        red_reg, green_reg, blue_reg;
    logic              last_reg;

    logic [PROD_W-1:0]         x_reg [3];
    logic [PROD_W+RECIP_W-1:0] p_reg [3];
    logic [7:0]                col   [3];
    logic [7:0]                lvl   [3];
    logic [QUOT_W-1:0]         quo   [3];
    logic [PROD_W-1:0]         rem   [3];
    logic [QUOT_W:0]           qcor  [3];
    logic [6:0]                per;
    logic [2:0]                sh1, sh2;

    logic       res_ok, res_last, emit, out_free, load;
    logic [1:0] res_op;
    logic [2:0] res_led;
    logic [7:0] res_red, res_green, res_blue;

    assign col[0] = job_reg.red;
    assign col[1] = job_reg.green;
    assign col[2] = job_reg.blue;
    assign per    = breath_period(job_reg.spd);
    assign sh1    = 3'd3 + {1'b0, job_reg.spd};
    assign sh2    = 3'd4 + {1'b0, job_reg.spd};

    // breath level: colour * step / period by reciprocal and one correction
    always_ff @(posedge aclk) begin
        for (int c = 0; c < 3; c++) begin
            x_reg[c] <= PROD_W'(col[c]) * PROD_W'(job_reg.stp);
            p_reg[c] <= x_reg[c] * breath_recip(job_reg.spd);
        end
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            quo[c]  = p_reg[c][PROD_W+RECIP_W-1:RECIP_SHIFT];
            rem[c]  = x_reg[c] - PROD_W'(quo[c]) * PROD_W'(per);
            qcor[c] = {1'b0, quo[c]} + ((rem[c] >= PROD_W'(per)) ? 1'b1 : 1'b0);
            lvl[c]  = (qcor[c] > (QUOT_W+1)'(255)) ? 8'hFF : qcor[c][7:0];
        end
    end

    always_comb begin
        res_ok    = busy_reg;
        res_op    = OP_WRITE_BUF;
        res_led   = 3'd0;
        res_red   = 8'd0;
        res_green = 8'd0;
        res_blue  = 8'd0;
        res_last  = 1'b0;
        if (step_reg == 3'd0) begin
            res_op = OP_CLEAR_ALL;
        end else begin
            unique case (job_reg.kind)
                JOB_WRITE: begin
                    res_op    = OP_WRITE_SHOW;
                    res_led   = job_reg.led;
                    res_red   = job_reg.red;
                    res_green = job_reg.green;
                    res_blue  = job_reg.blue;
                    res_last  = 1'b1;
                end
                JOB_METEOR: begin
                    unique case (step_reg)
                        3'd1: begin
                            res_led   = map_led({1'b0, job_reg.led});
                            res_red   = job_reg.red;
                            res_green = job_reg.green;
                            res_blue  = job_reg.blue;
                        end
                        3'd2: begin
                            res_led   = map_led({1'b0, job_reg.led} + 4'd5);
                            res_red   = job_reg.red >> sh1;
                            res_green = job_reg.green >> sh1;
                            res_blue  = job_reg.blue >> sh1;
                        end
                        3'd3: begin
                            res_led   = map_led({1'b0, job_reg.led} + 4'd4);
                            res_red   = job_reg.red >> sh2;
                            res_green = job_reg.green >> sh2;
                            res_blue  = job_reg.blue >> sh2;
                        end
                        3'd4: res_led = map_led({1'b0, job_reg.led} + 4'd3);
                        3'd5: res_led = map_led({1'b0, job_reg.led} + 4'd2);
                        3'd6: res_led = map_led({1'b0, job_reg.led} + 4'd1);
                        default: begin
                            res_op   = OP_LATCH;
                            res_last = 1'b1;
                        end
                    endcase
                end
                JOB_BREATH: begin
                    res_ok    = busy_reg && (bwait_reg == 2'd0);
                    res_op    = OP_WRITE_SHOW;
                    res_led   = job_reg.led;
                    res_red   = lvl[0];
                    res_green = lvl[1];
                    res_blue  = lvl[2];
                    res_last  = 1'b1;
                end
                default: res_last = 1'b1;
            endcase
        end
    end

    assign out_free = !out_valid_reg || m_tready;
    assign emit     = res_ok && out_free;
    assign load     = (!busy_reg || (emit && res_last)) && !q_empty;
    assign q_pop    = load;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            step_reg      <= 3'd0;
            bwait_reg     <= 2'd0;
            out_valid_reg <= 1'b0;
        end else begin
            if (emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (load) begin
                busy_reg  <= 1'b1;
                step_reg  <= q_job.clear_first ? 3'd0 : 3'd1;
                bwait_reg <= 2'd2;
            end else begin
                if (emit && res_last) begin
                    busy_reg <= 1'b0;
                end else if (emit) begin
                    step_reg <= step_reg + 3'd1;
                end
                if (bwait_reg != 2'd0) begin
                    bwait_reg <= bwait_reg - 2'd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            job_reg <= q_job;
        end
        if (emit) begin
            op_reg    <= res_op;
            led_reg   <= res_led;
            red_reg   <= res_red;
            green_reg <= res_green;
            blue_reg  <= res_blue;
            last_reg  <= res_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = op_reg;
    assign m_tlast  = last_reg;
    assign m_tdata  = {5'd0, blue_reg, green_reg, red_reg, led_reg};

    a_clear_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == OP_CLEAR_ALL |-> !m_tlast)
        else $error("clear all ended an item");
    a_latch_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == OP_LATCH |-> m_tlast && m_tdata[2:0] == 3'd0)
        else $error("latch not last or with led");
    a_show_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == OP_WRITE_SHOW |-> m_tlast)
        else $error("write and show not last");
    a_buf_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == OP_WRITE_BUF |-> !m_tlast)
        else $error("buffer write ended an item");

endmodule

### design/rgb_led_effect_engine_unit.sv
// ----------------------------------------------------------------------------
// rgb_led_effect_engine_unit
// effect engine for six rgb leds: static colour, clear, meteor and breath
// ----------------------------------------------------------------------------
// A request is taken whenever the four-entry job queue has room, so requests
// may arrive back to back. Each request produces zero to eight led writes,
// delivered one per cycle from the output register while the receiver is
// ready; a meteor frame is seven or eight results, and a breath write waits
// for its level to pass the x_reg and p_reg registers of the reciprocal divide
// pipeline. The sustained rate is set by the back end emitting one result per
// cycle when not stalled by the receiver or by a pending breath level.
module rgb_led_effect_engine_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,  // led_index, speed, red, green, blue, clear_others
    input  logic [2:0]  s_tuser,  // action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,  // led_select, out_red, out_green, out_blue
    output logic [1:0]  m_tuser,  // op
    output logic        m_tlast
);
    import rlee_pkg::*;

    logic q_push, q_full, q_pop, q_empty;
    job_t push_job, pop_job;

    rlee_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_job    (push_job)
    );

    rlee_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (q_pop),
        .pop_job  (pop_job),
        .empty    (q_empty)
    );

    rlee_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .q_job    (pop_job),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

### sim/rgb_led_effect_engine_unit_test.sv
// ----------------------------------------------------------------------------
// rgb_led_effect_engine_unit_test
// self-checking bench: drives tick and command requests through the stream
// input with random bursts and gaps, predicts every led write of each request
// and compares the result stream field by field under random back pressure
// ----------------------------------------------------------------------------
module rgb_led_effect_engine_unit_test;

    timeunit 1ns;
    timeprecision 1ps;

    import rlee_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 40;
    localparam int RANDOM_REQUESTS = 80;

    typedef struct {
        logic [2:0] action;
        logic [2:0] led;
        logic [1:0] speed;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       clr;
    } led_cmd_t;

    typedef struct {
        logic [1:0] op;
        logic [2:0] led;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last;
    } led_write_t;

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic [2:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    rgb_led_effect_engine_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    led_write_t expected_writes[$];
    int         error_count = 0;
    int         burst_left = 0;
    bit         rx_hold_request = 1'b0;

    // predicted engine state
    logic [1:0]  fx_mode;
    logic [1:0]  fx_speed;
    logic [7:0]  fx_red;
    logic [7:0]  fx_green;
    logic [7:0]  fx_blue;
    logic [2:0]  fx_pos;
    logic [7:0]  fx_step;
    logic [31:0] now_ms_q;
    logic [31:0] due_ms;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic logic [31:0] frame_ms(input logic [1:0] s);
        case (s)
            2'd0:    return 32'd200;
            2'd1:    return 32'd140;
            default: return 32'd80;
        endcase
    endfunction

    function automatic int unsigned ramp_ms(input logic [1:0] s);
        case (s)
            2'd0:    return 50;
            2'd1:    return 35;
            default: return 25;
        endcase
    endfunction

    function automatic logic [2:0] led_wrap(input int unsigned id);
        if (id == 0) return 3'd0;
        return 3'(((id - 1) % LED_COUNT) + 1);
    endfunction

    function automatic logic [7:0] fade_level(input logic [7:0] c, input int unsigned stp,
                                              input int unsigned per);
        int unsigned v;
        v = (c * stp) / per;
        return (v > 255) ? 8'd255 : 8'(v);
    endfunction

    function automatic void queue_write(input logic [1:0] op, input logic [2:0] led,
                                        input logic [7:0] r, input logic [7:0] g,
                                        input logic [7:0] b);
        led_write_t w;
        w.op = op;
        w.led = led;
        w.red = r;
        w.green = g;
        w.blue = b;
        w.last = 1'b0;
        expected_writes.push_back(w);
    endfunction

    function automatic int meteor_frame();
        int unsigned sh1;
        int unsigned sh2;
        if (now_ms_q < due_ms) return 0;
        sh1 = 3 + fx_speed;
        sh2 = 4 + fx_speed;
        due_ms = due_ms + frame_ms(fx_speed);
        queue_write(OP_WRITE_BUF, led_wrap(fx_pos), fx_red, fx_green, fx_blue);
        queue_write(OP_WRITE_BUF, led_wrap(fx_pos + 5),
                    fx_red >> sh1, fx_green >> sh1, fx_blue >> sh1);
        queue_write(OP_WRITE_BUF, led_wrap(fx_pos + 4),
                    fx_red >> sh2, fx_green >> sh2, fx_blue >> sh2);
        for (int k = 3; k >= 1; k--) begin
            queue_write(OP_WRITE_BUF, led_wrap(fx_pos + k), 8'd0, 8'd0, 8'd0);
        end
        queue_write(OP_LATCH, 3'd0, 8'd0, 8'd0, 8'd0);
        fx_pos = (fx_pos >= 3'd6) ? 3'd1 : fx_pos + 3'd1;
        return 7;
    endfunction

    function automatic int breath_frame();
        int unsigned per;
        int unsigned stp;
        logic [7:0]  r;
        logic [7:0]  g;
        logic [7:0]  b;
        if (now_ms_q < due_ms) return 0;
        per = ramp_ms(fx_speed);
        stp = fx_step[6:0];
        due_ms = now_ms_q + per;
        r = fade_level(fx_red, stp, per);
        g = fade_level(fx_green, stp, per);
        b = fade_level(fx_blue, stp, per);
        if (fx_step[7]) begin
            fx_step = fx_step - 8'd1;
            if (fx_step == STEP_FALL_END) fx_step = STEP_RISE_BASE;
        end else begin
            fx_step = fx_step + 8'd1;
            if (fx_step == 8'(per)) fx_step = STEP_FALL_FLAG | 8'(per);
        end
        queue_write(OP_WRITE_SHOW, fx_pos, r, g, b);
        return 1;
    endfunction

    function automatic int run_effect();
        if (fx_mode == MODE_METEOR) return meteor_frame();
        if (fx_mode == MODE_BREATH) return breath_frame();
        return 0;
    endfunction

    function automatic void predict_led_writes(input led_cmd_t c);
        int         n;
        logic [1:0] spd;
        led_write_t w;
        n = 0;
        spd = (c.speed > SPEED_MAX) ? SPEED_MAX : c.speed;
        case (c.action)
            ACT_TICK: begin
                now_ms_q = now_ms_q + 32'd1;
                n = run_effect();
            end
            ACT_COLOR: begin
                if (c.led != LED_NONE) begin
                    if (c.clr) begin
                        queue_write(OP_CLEAR_ALL, 3'd0, 8'd0, 8'd0, 8'd0);
                        n++;
                    end
                    queue_write(OP_WRITE_SHOW, c.led, c.red, c.green, c.blue);
                    n++;
                    fx_mode = MODE_COLOR;
                end
            end
            ACT_METEOR: begin
                if (fx_mode != MODE_METEOR || fx_speed != spd || fx_red != c.red ||
                    fx_green != c.green || fx_blue != c.blue) begin
                    fx_speed = spd;
                    fx_red = c.red;
                    fx_green = c.green;
                    fx_blue = c.blue;
                    fx_pos = 3'd0;
                    due_ms = now_ms_q;
                    queue_write(OP_CLEAR_ALL, 3'd0, 8'd0, 8'd0, 8'd0);
                    n++;
                    fx_mode = MODE_METEOR;
                end
                n += run_effect();
            end
            ACT_BREATH: begin
                if (c.led != LED_NONE) begin
                    if (fx_mode != MODE_BREATH || fx_pos != c.led || fx_speed != spd ||
                        fx_red != c.red || fx_green != c.green || fx_blue != c.blue) begin
                        fx_speed = spd;
                        fx_red = c.red;
                        fx_green = c.green;
                        fx_blue = c.blue;
                        fx_pos = c.led;
                        fx_step = 8'd0;
                        due_ms = now_ms_q;
                        queue_write(OP_CLEAR_ALL, 3'd0, 8'd0, 8'd0, 8'd0);
                        n++;
                        fx_mode = MODE_BREATH;
                    end
                    n += run_effect();
                end
            end
            ACT_CLEAR: begin
                if (c.led != LED_NONE) begin
                    queue_write(OP_WRITE_SHOW, c.led, 8'd0, 8'd0, 8'd0);
                    n++;
                    fx_mode = MODE_CLEAR;
                end
            end
            default: begin
            end
        endcase
        if (n > 0) begin
            w = expected_writes.pop_back();
            w.last = 1'b1;
            expected_writes.push_back(w);
        end
    endfunction

    // sender: random bursts separated by random gaps
    task automatic send_request(input led_cmd_t c);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser <= c.action;
        s_tdata <= {2'b00, c.clr, c.blue, c.green, c.red, c.speed, c.led};
        do @(posedge aclk); while (!s_tready);
        predict_led_writes(c);
    endtask

    function automatic led_cmd_t make_cmd(input logic [2:0] action, input logic [2:0] led,
                                          input logic [1:0] speed, input logic [7:0] r,
                                          input logic [7:0] g, input logic [7:0] b,
                                          input logic clr);
        led_cmd_t c;
        c.action = action;
        c.led = led;
        c.speed = speed;
        c.red = r;
        c.green = g;
        c.blue = b;
        c.clr = clr;
        return c;
    endfunction

    function automatic logic [7:0] pick_level();
        case ($urandom_range(0, 5))
            0:       return 8'h00;
            1:       return 8'hff;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic led_cmd_t random_cmd();
        return make_cmd(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                        2'($urandom_range(0, 3)), pick_level(), pick_level(), pick_level(),
                        1'($urandom_range(0, 1)));
    endfunction

    task automatic send_ticks(input int count);
        for (int i = 0; i < count; i++) begin
            send_request(make_cmd(ACT_TICK, 3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)),
                                  pick_level(), pick_level(), pick_level(),
                                  1'($urandom_range(0, 1))));
        end
    endtask

    task automatic test_static_and_clear();
        send_request(make_cmd(ACT_COLOR, 3'd0, 2'd0, 8'hff, 8'hff, 8'hff, 1'b1));
        send_request(make_cmd(ACT_COLOR, 3'd6, 2'd3, 8'h00, 8'h00, 8'h00, 1'b0));
        send_request(make_cmd(ACT_COLOR, 3'd1, 2'd1, 8'h80, 8'h7f, 8'h81, 1'b1));
        send_request(make_cmd(ACT_COLOR, LED_NONE, 2'd0, 8'hff, 8'h00, 8'hff, 1'b1));
        send_ticks(2);
        send_request(make_cmd(ACT_CLEAR, 3'd3, 2'd2, 8'hff, 8'hff, 8'hff, 1'b1));
        send_request(make_cmd(ACT_CLEAR, LED_NONE, 2'd0, 8'h00, 8'h00, 8'h00, 1'b0));
        send_ticks(1);
        for (int a = ACT_CLEAR + 1; a <= 7; a++) begin
            send_request(make_cmd(3'(a), 3'(a), 2'd3, 8'hff, 8'hff, 8'hff, 1'b1));
        end
    endtask

    task automatic test_meteor_start();
        send_request(make_cmd(ACT_METEOR, 3'd2, 2'd0, 8'hff, 8'h80, 8'h7f, 1'b0));
        send_request(make_cmd(ACT_METEOR, 3'd5, 2'd0, 8'hff, 8'h80, 8'h7f, 1'b1));
        send_ticks(2);
        send_request(make_cmd(ACT_METEOR, LED_NONE, 2'd3, 8'hff, 8'hff, 8'hff, 1'b0));
        send_request(make_cmd(ACT_METEOR, 3'd0, 2'd2, 8'hff, 8'hff, 8'hff, 1'b0));
        send_request(make_cmd(ACT_METEOR, 3'd0, 2'd1, 8'h00, 8'h00, 8'h00, 1'b0));
    endtask

    task automatic test_breath_start();
        send_request(make_cmd(ACT_BREATH, LED_NONE, 2'd0, 8'hff, 8'hff, 8'hff, 1'b0));
        send_request(make_cmd(ACT_BREATH, 3'd0, 2'd0, 8'hff, 8'hff, 8'hff, 1'b0));
        send_request(make_cmd(ACT_BREATH, 3'd0, 2'd0, 8'hff, 8'hff, 8'hff, 1'b0));
        send_request(make_cmd(ACT_BREATH, 3'd6, 2'd3, 8'h80, 8'h01, 8'hfe, 1'b1));
        send_ticks(1);
    endtask

    // tick runs: timed meteor frames and breath ramp steps
    task automatic test_effect_long_run();
        send_request(make_cmd(ACT_METEOR, 3'd1, 2'd3, 8'hc8, 8'h3f, 8'hff, 1'b0));
        send_ticks(90);
        send_request(make_cmd(ACT_BREATH, 3'd4, 2'd3, 8'hff, 8'hff, 8'hff, 1'b0));
        send_ticks(55);
        send_request(make_cmd(ACT_BREATH, 3'd2, 2'd1, 8'hff, 8'h80, 8'h01, 1'b0));
        send_ticks(40);
    endtask

    // receiver holds off while requests keep coming, so the job queue fills
    task automatic test_backpressure();
        rx_hold_request = 1'b1;
        for (int i = 0; i < 16; i++) begin
            send_request(make_cmd(ACT_METEOR, 3'(i), 2'(i), 8'(i * 16), 8'hff - 8'(i),
                                  8'(i), 1'b0));
        end
    endtask

    task automatic test_random_traffic(input int target);
        int       counted;
        int       pick;
        led_cmd_t c;
        counted = 0;
        while (counted < target) begin
            pick = $urandom_range(0, 9);
            c = random_cmd();
            if (pick < 5) begin
                c.action = $urandom_range(0, 1) ? ACT_METEOR : ACT_BREATH;
                if (c.action == ACT_BREATH && $urandom_range(0, 7) != 0) begin
                    c.led = 3'($urandom_range(0, 6));
                end
                if ($urandom_range(0, 2) == 0) begin
                    c.speed = fx_speed;
                    c.red = fx_red;
                    c.green = fx_green;
                    c.blue = fx_blue;
                    if (c.action == ACT_BREATH) c.led = fx_pos;
                end
                send_request(c);
                counted++;
                pick = $urandom_range(0, 30);
                send_ticks(pick);
                counted += pick;
            end else if (pick < 8) begin
                c.action = $urandom_range(0, 1) ? ACT_COLOR : ACT_CLEAR;
                send_request(c);
                if (c.led != LED_NONE) counted++;
            end else begin
                send_request(c);
                if (c.action <= ACT_CLEAR && (c.led != LED_NONE || c.action == ACT_TICK ||
                                              c.action == ACT_METEOR)) counted++;
            end
        end
    endtask

    // receiver stall pattern, picked at random for each window
    initial begin
        int rx_style;
        int rx_window;
        int hold_left;
        rx_style = 0;
        rx_window = 0;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (rx_hold_request) begin
                rx_hold_request = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (rx_window == 0) begin
                rx_style = $urandom_range(0, 3);
                rx_window = 48;
            end
            rx_window--;
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                case (rx_style)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= 1'($urandom_range(0, 1));
                    2:       m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= rx_window[1];
                endcase
            end
        end
    end

    // result checker
    initial begin
        led_write_t w;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                if (expected_writes.size() == 0) begin
                    $display("%0t: unexpected led write op=%0d led=%0d rgb=%h last=%b", $realtime,
                             m_tuser, m_tdata[2:0], m_tdata[26:3], m_tlast);
                    error_count++;
                end else begin
                    w = expected_writes.pop_front();
                    if (m_tuser !== w.op || m_tdata[2:0] !== w.led ||
                        m_tdata[10:3] !== w.red || m_tdata[18:11] !== w.green ||
                        m_tdata[26:19] !== w.blue || m_tlast !== w.last) begin
                        $display("%0t: led write mismatch: expected op=%0d led=%0d r=%h g=%h b=%h last=%b, got op=%0d led=%0d r=%h g=%h b=%h last=%b",
                                 $realtime, w.op, w.led, w.red, w.green, w.blue, w.last,
                                 m_tuser, m_tdata[2:0], m_tdata[10:3], m_tdata[18:11],
                                 m_tdata[26:19], m_tlast);
                        error_count++;
                    end
                end
            end
        end
    end

    initial begin
        int cycles;
        cycles = 0;
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("%0t: timeout with %0d led writes outstanding", $realtime,
                         expected_writes.size());
                $display("rgb_led_effect_engine_unit regression: fail");
                $finish;
            end
        end
    end

    initial begin
        fx_mode = MODE_CLEAR;
        fx_speed = 2'd0;
        fx_red = 8'd0;
        fx_green = 8'd0;
        fx_blue = 8'd0;
        fx_pos = 3'd0;
        fx_step = 8'd0;
        now_ms_q = 32'd0;
        due_ms = 32'd0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_static_and_clear();
        test_meteor_start();
        test_breath_start();
        test_effect_long_run();
        test_backpressure();
        test_random_traffic(RANDOM_REQUESTS);
        s_tvalid <= 1'b0;
        while (expected_writes.size() > 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("rgb_led_effect_engine_unit regression: pass");
        end else begin
            $display("rgb_led_effect_engine_unit regression: fail");
        end
        $finish;
    end

endmodule

### filelist.f
design/rlee_pkg.sv
design/rlee_front.sv
design/rlee_queue.sv
design/rlee_back.sv
design/rgb_led_effect_engine_unit.sv
sim/rgb_led_effect_engine_unit_test.sv
